/* sv/mtep_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// MIDI track event parser package
// Item and result types, record kinds and status byte codes shared by the
// parser core and the top level.
// ---------------------------------------------------------------------------
package mtep_pkg;

    localparam int VLQ_MAX_BYTES_DEF = 4;

    typedef enum logic [2:0] {
        KIND_NOTE_OFF   = 3'd0,
        KIND_NOTE_ON    = 3'd1,
        KIND_TEMPO      = 3'd2,
        KIND_CHANNEL    = 3'd3,
        KIND_META       = 3'd4,
        KIND_BAD_STATUS = 3'd5,
        KIND_BAD_HEADER = 3'd6
    } t_kind;

    // Status byte codes and channel message high nibbles.
    localparam logic [7:0] STATUS_META   = 8'hFF;
    localparam logic [7:0] META_TEMPO    = 8'h51;
    localparam logic [3:0] NIB_NOTE_OFF  = 4'h8;
    localparam logic [3:0] NIB_NOTE_ON   = 4'h9;
    localparam logic [3:0] NIB_POLY_AT   = 4'hA;
    localparam logic [3:0] NIB_CONTROL   = 4'hB;
    localparam logic [3:0] NIB_PROGRAM   = 4'hC;
    localparam logic [3:0] NIB_CHAN_AT   = 4'hD;
    localparam logic [3:0] NIB_PITCH     = 4'hE;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       start_of_track;
    } t_item;

    typedef struct packed {
        t_kind       kind;
        logic [27:0] delta_ticks;
        logic [7:0]  status_byte;
        logic [7:0]  first_param;
        logic [7:0]  second_param;
        logic [7:0]  meta_kind;
        logic [27:0] meta_size;
        logic [23:0] tempo_us;
        logic        track_done;
    } t_result;

    // The four bytes of the chunk tag "MTrk".
    function automatic logic [7:0] tag_byte(input logic [1:0] idx);
        logic [7:0] b;
        case (idx)
            2'd0:    b = 8'h4D;
            2'd1:    b = 8'h54;
            2'd2:    b = 8'h72;
            default: b = 8'h6B;
        endcase
        return b;
    endfunction

endpackage
`default_nettype wire

/* sv/midi_track_event_parser.sv */
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// MIDI track event parser
// Parses the bytes of one track chunk and emits one record per event.
// ---------------------------------------------------------------------------
// Usage: the input channel carries one chunk byte per item, with
// start_of_track set on the first byte ("M") of each chunk. The output
// channel carries one record for every completed event and one error record
// for a bad tag or an unsupported status, after which the block ignores bytes
// until the next track start. Both channels use valid and stall.
// Path: the byte completing an event passes the input register, then the parse
// step, which pushes its record into a two-entry result queue; the record is
// valid on the output while it heads that queue.
// Throughput: one byte per cycle unless the queue is full; the parse step is a
// single pass of shifts and compares, so it runs at the input register's rate.
// When the receiver stalls, the result queue absorbs one more record; the
// input stalls only while the queue is full and a byte waits to be parsed.
// After reset the block is halted and holds no records: bytes are dropped
// until one arrives with start_of_track set.
// ---------------------------------------------------------------------------
module midi_track_event_parser #(
    parameter int VLQ_MAX_BYTES = mtep_pkg::VLQ_MAX_BYTES_DEF
) (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_in_valid,
    input  mtep_pkg::t_item   i_in_item,
    output logic              o_in_stall,
    output logic              o_out_valid,
    output mtep_pkg::t_result o_out_item,
    input  wire               i_out_stall
);
    import mtep_pkg::*;

    logic    r_in_valid, n_in_valid;
    t_item   r_in;
    logic    load;
    logic    advance;
    logic    pop;
    logic    push;
    logic    res_valid;
    t_result res;
    t_result r_q0, n_q0;
    t_result r_q1, n_q1;
    logic [1:0] r_cnt, n_cnt;

    assign advance    = r_in_valid && (r_cnt != 2'd2);
    assign o_in_stall = r_in_valid && !advance;
    assign load       = i_in_valid && !o_in_stall;
    assign n_in_valid = load || (r_in_valid && !advance);

    mtep_parse #(
        .VLQ_MAX_BYTES(VLQ_MAX_BYTES)
    ) u_parse (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_step     (advance),
        .i_item     (r_in),
        .o_res_valid(res_valid),
        .o_res      (res)
    );

    assign push        = res_valid;
    assign o_out_valid = (r_cnt != 2'd0);
    assign o_out_item  = r_q0;
    assign pop         = o_out_valid && !i_out_stall;

    always_comb begin
        n_q0  = r_q0;
        n_q1  = r_q1;
        n_cnt = r_cnt;
        case ({push, pop})
            2'b01: begin
                n_q0  = r_q1;
                n_cnt = r_cnt - 2'd1;
            end
            2'b10: begin
                if (r_cnt == 2'd0) begin
                    n_q0 = res;
                end else begin
                    n_q1 = res;
                end
                n_cnt = r_cnt + 2'd1;
            end
            2'b11: begin
                if (r_cnt == 2'd1) begin
                    n_q0 = res;
                end else begin
                    n_q0 = r_q1;
                    n_q1 = res;
                end
            end
            default: begin
                n_cnt = r_cnt;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_cnt      <= 2'd0;
        end else begin
            r_in_valid <= n_in_valid;
            r_cnt      <= n_cnt;
        end
        if (load) begin
            r_in <= i_in_item;
        end
        r_q0 <= n_q0;
        r_q1 <= n_q1;
    end

    // The result queue never overflows and never counts past two.
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd2) |-> !push)
        else $error("result pushed into a full queue");

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3)
        else $error("result queue count out of range");

    // Error records never claim the end of the chunk.
    a_err_not_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && (res.kind == KIND_BAD_STATUS || res.kind == KIND_BAD_HEADER))
        |-> !res.track_done)
        else $error("error record marked as track end");

    // A byte that cannot advance is kept for the next cycle.
    a_in_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !advance) |=> (r_in_valid && $stable(r_in)))
        else $error("waiting byte lost");

endmodule
`default_nettype wire

/* sv/mtep_parse.sv */
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// MIDI track event parser core
// Holds the parse state and updates it from one byte per step, producing at
// most one event record in the same step.
// ---------------------------------------------------------------------------
module mtep_parse #(
    parameter int VLQ_MAX_BYTES = mtep_pkg::VLQ_MAX_BYTES_DEF
) (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_step,
    input  mtep_pkg::t_item   i_item,
    output logic              o_res_valid,
    output mtep_pkg::t_result o_res
);
    import mtep_pkg::*;

    localparam logic [2:0] VLQ_LIMIT = 3'(VLQ_MAX_BYTES);

    typedef enum logic [3:0] {
        PH_TAG, PH_LEN, PH_DELTA, PH_STATUS, PH_PARAM1,
        PH_PARAM2, PH_MTYPE, PH_MLEN, PH_MDATA
    } t_phase;

    t_phase      r_phase, n_phase, c_phase;
    logic [2:0]  r_fc, n_fc, c_fc;
    logic [27:0] r_vlq, n_vlq, c_vlq;
    logic [27:0] r_delta, n_delta, c_delta;
    logic [7:0]  r_status, n_status, c_status;
    logic [7:0]  r_param, n_param, c_param;
    logic [7:0]  r_mtype, n_mtype, c_mtype;
    logic [27:0] r_mrem, n_mrem, c_mrem;
    logic [27:0] r_mlen, n_mlen, c_mlen;
    logic [23:0] r_tempo, n_tempo, c_tempo;
    logic [31:0] r_chunk, n_chunk, c_chunk;
    logic [31:0] r_bytes, n_bytes, c_bytes;
    logic        r_halted, n_halted, c_halted;

    logic        clr;
    logic [7:0]  b;
    logic [27:0] vlq_acc;
    logic [2:0]  vlq_fc;
    logic        vlq_end;
    logic        emit;
    logic        emit_err;
    logic        emit_meta;
    t_kind       emit_kind;
    logic [7:0]  emit_p1;
    logic [7:0]  emit_p2;
    logic        done;
    logic [3:0]  hi;

    assign clr = i_step && i_item.start_of_track;
    assign b   = i_item.data_byte;

    // A track start clears the parser before its byte is taken.
    always_comb begin
        c_phase  = clr ? PH_TAG : r_phase;
        c_fc     = clr ? 3'd0   : r_fc;
        c_vlq    = clr ? '0     : r_vlq;
        c_delta  = clr ? '0     : r_delta;
        c_status = clr ? '0     : r_status;
        c_param  = clr ? '0     : r_param;
        c_mtype  = clr ? '0     : r_mtype;
        c_mrem   = clr ? '0     : r_mrem;
        c_mlen   = clr ? '0     : r_mlen;
        c_tempo  = clr ? '0     : r_tempo;
        c_chunk  = clr ? '0     : r_chunk;
        c_bytes  = clr ? '0     : r_bytes;
        c_halted = clr ? 1'b0   : r_halted;
    end

    assign vlq_acc = {c_vlq[20:0], b[6:0]};
    assign vlq_fc  = c_fc + 3'd1;
    assign vlq_end = !b[7] || (vlq_fc >= VLQ_LIMIT);

    always_comb begin
        n_phase  = c_phase;
        n_fc     = c_fc;
        n_vlq    = c_vlq;
        n_delta  = c_delta;
        n_status = c_status;
        n_param  = c_param;
        n_mtype  = c_mtype;
        n_mrem   = c_mrem;
        n_mlen   = c_mlen;
        n_tempo  = c_tempo;
        n_chunk  = c_chunk;
        n_bytes  = c_bytes;
        n_halted = c_halted;
        emit      = 1'b0;
        emit_err  = 1'b0;
        emit_meta = 1'b0;
        emit_kind = KIND_CHANNEL;
        emit_p1   = '0;
        emit_p2   = '0;
        hi        = c_status[7:4];
        done      = 1'b0;
        o_res_valid = 1'b0;
        o_res       = '0;

        if (i_step && !c_halted) begin
            if (c_phase != PH_TAG && c_phase != PH_LEN && c_bytes != 32'hFFFF_FFFF) begin
                n_bytes = c_bytes + 32'd1;
            end
            case (c_phase)
                PH_TAG: begin
                    if (b != tag_byte(c_fc[1:0])) begin
                        emit      = 1'b1;
                        emit_err  = 1'b1;
                        emit_kind = KIND_BAD_HEADER;
                    end else begin
                        n_fc = c_fc + 3'd1;
                        if (n_fc >= 3'd4) begin
                            n_phase = PH_LEN;
                            n_fc    = 3'd0;
                        end
                    end
                end
                PH_LEN: begin
                    n_chunk = {c_chunk[23:0], b};
                    n_fc    = c_fc + 3'd1;
                    if (n_fc >= 3'd4) begin
                        if (n_chunk == 32'd0) begin
                            n_halted = 1'b1;
                        end else begin
                            n_phase = PH_DELTA;
                            n_fc    = 3'd0;
                            n_vlq   = '0;
                        end
                    end
                end
                PH_DELTA: begin
                    n_vlq = vlq_acc;
                    n_fc  = vlq_fc;
                    if (vlq_end) begin
                        n_delta = vlq_acc;
                        n_phase = PH_STATUS;
                    end
                end
                PH_STATUS: begin
                    n_status = b;
                    if (b == STATUS_META) begin
                        n_phase = PH_MTYPE;
                    end else if (b[7:4] == NIB_NOTE_OFF || b[7:4] == NIB_NOTE_ON ||
                                 b[7:4] == NIB_POLY_AT || b[7:4] == NIB_CONTROL ||
                                 b[7:4] == NIB_PITCH || b[7:4] == NIB_PROGRAM ||
                                 b[7:4] == NIB_CHAN_AT) begin
                        n_phase = PH_PARAM1;
                    end else begin
                        emit      = 1'b1;
                        emit_err  = 1'b1;
                        emit_kind = KIND_BAD_STATUS;
                    end
                end
                PH_PARAM1: begin
                    if (hi == NIB_PROGRAM || hi == NIB_CHAN_AT) begin
                        emit      = 1'b1;
                        emit_kind = KIND_CHANNEL;
                        emit_p1   = b;
                    end else begin
                        n_param = b;
                        n_phase = PH_PARAM2;
                    end
                end
                PH_PARAM2: begin
                    emit    = 1'b1;
                    emit_p1 = c_param;
                    emit_p2 = b;
                    // A note-on with zero velocity is a note-off.
                    if (hi == NIB_NOTE_OFF || (hi == NIB_NOTE_ON && b == 8'd0)) begin
                        emit_kind = KIND_NOTE_OFF;
                    end else if (hi == NIB_NOTE_ON) begin
                        emit_kind = KIND_NOTE_ON;
                    end else begin
                        emit_kind = KIND_CHANNEL;
                    end
                end
                PH_MTYPE: begin
                    n_mtype = b;
                    n_phase = PH_MLEN;
                    n_fc    = 3'd0;
                    n_vlq   = '0;
                end
                PH_MLEN: begin
                    n_vlq = vlq_acc;
                    n_fc  = vlq_fc;
                    if (vlq_end) begin
                        n_mlen  = vlq_acc;
                        n_mrem  = vlq_acc;
                        n_tempo = '0;
                        if (vlq_acc == 28'd0) begin
                            emit      = 1'b1;
                            emit_meta = 1'b1;
                        end else begin
                            n_phase = PH_MDATA;
                        end
                    end
                end
                PH_MDATA: begin
                    // Only the first three data bytes are gathered into the tempo.
                    if ((c_mlen - c_mrem) < 28'd3) begin
                        n_tempo = {c_tempo[15:0], b};
                    end
                    n_mrem = c_mrem - 28'd1;
                    if (n_mrem == 28'd0) begin
                        emit      = 1'b1;
                        emit_meta = 1'b1;
                    end
                end
                default: begin
                    n_halted = 1'b1;
                end
            endcase

            if (emit_meta) begin
                emit_kind = (n_mtype == META_TEMPO) ? KIND_TEMPO : KIND_META;
            end

            if (emit) begin
                done = !emit_err && (n_bytes >= n_chunk);
                o_res_valid        = 1'b1;
                o_res.kind         = emit_kind;
                o_res.delta_ticks  = (emit_kind == KIND_BAD_HEADER) ? '0 : n_delta;
                o_res.status_byte  = (emit_kind == KIND_BAD_HEADER) ? '0 : n_status;
                o_res.first_param  = emit_p1;
                o_res.second_param = emit_p2;
                o_res.meta_kind    = emit_meta ? n_mtype : 8'd0;
                o_res.meta_size    = emit_meta ? n_mlen : 28'd0;
                o_res.tempo_us     = (emit_kind == KIND_TEMPO) ? n_tempo : 24'd0;
                o_res.track_done   = done;
                if (emit_err || done) begin
                    n_halted = 1'b1;
                end else begin
                    n_phase = PH_DELTA;
                    n_fc    = 3'd0;
                    n_vlq   = '0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_TAG;
            r_fc     <= '0;
            r_vlq    <= '0;
            r_delta  <= '0;
            r_status <= '0;
            r_param  <= '0;
            r_mtype  <= '0;
            r_mrem   <= '0;
            r_mlen   <= '0;
            r_tempo  <= '0;
            r_chunk  <= '0;
            r_bytes  <= '0;
            r_halted <= 1'b1;
        end else begin
            r_phase  <= n_phase;
            r_fc     <= n_fc;
            r_vlq    <= n_vlq;
            r_delta  <= n_delta;
            r_status <= n_status;
            r_param  <= n_param;
            r_mtype  <= n_mtype;
            r_mrem   <= n_mrem;
            r_mlen   <= n_mlen;
            r_tempo  <= n_tempo;
            r_chunk  <= n_chunk;
            r_bytes  <= n_bytes;
            r_halted <= n_halted;
        end
    end

endmodule
`default_nettype wire
